// ===== rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console character engine
// Screen geometry, control codes, command kinds and address helpers.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int LOC_W      = 11;
  localparam int TAB_STOP   = 8;

  // Control and character codes
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] PRINT_LAST = 8'h7F;
  localparam logic [7:0] RESET_ATTR = 8'h0F;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  // Configuration port
  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_TEXT_ATTR = 1'b0;

  // Command queue
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // Operation codes of the input item
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Classified command kinds
  typedef enum logic [2:0] {
    K_NOP,
    K_CR,
    K_LF,
    K_BS,
    K_TAB,
    K_PRINT,
    K_READ,
    K_READ_OFF
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       code;
    logic [ROW_W-1:0] rrow;
    logic [COL_W-1:0] rcol;
  } cmd_t;

  // Map a screen row to its row in the store, given the top row pointer
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, row} + {1'b0, top};
    if (int'(sum) >= ROWS) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  // Linear store address of a cell
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(int'(prow) * COLUMNS + int'(col));
  endfunction

  // Linear cursor location, low bits only
  function automatic logic [LOC_W-1:0] loc_of(input logic [ROW_W-1:0] row,
                                              input logic [COL_W-1:0] col);
    return LOC_W'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

// ===== rtl/tcce_front.sv =====
// ----------------------------------------------------------------------------
// tcce_front: input stage
// Accepts input items, classifies the byte or read request and holds the
// command until the command queue takes it.
// ----------------------------------------------------------------------------
module tcce_front import tcce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       operation,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [6:0] read_column,
  input  logic       clearing,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_din
);

  logic  front_valid;
  cmd_t  front_cmd;
  cmd_t  cls_cmd;
  logic  accept;

  // Classify the incoming item
  always_comb begin
    cls_cmd.code = char_code;
    cls_cmd.rrow = ROW_W'(read_row);
    cls_cmd.rcol = COL_W'(read_column);
    if (operation == OP_READ) begin
      if (int'(read_row) < ROWS && int'(read_column) < COLUMNS) begin
        cls_cmd.kind = K_READ;
      end else begin
        cls_cmd.kind = K_READ_OFF;
      end
    end else begin
      priority if (char_code == CH_CR) begin
        cls_cmd.kind = K_CR;
      end else if (char_code == CH_LF) begin
        cls_cmd.kind = K_LF;
      end else if (char_code == CH_BS) begin
        cls_cmd.kind = K_BS;
      end else if (char_code == CH_TAB) begin
        cls_cmd.kind = K_TAB;
      end else if (char_code >= CH_SPACE && char_code <= PRINT_LAST) begin
        cls_cmd.kind = K_PRINT;
      end else begin
        cls_cmd.kind = K_NOP;
      end
    end
  end

  // Hand the held command on when the queue has room
  assign q_push = front_valid && !q_full;
  assign q_din  = front_cmd;
  assign full   = clearing || (front_valid && q_full);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (q_push) begin
      front_valid <= 1'b0;
    end
  end

  // Capture the classified command
  always_ff @(posedge clk) begin
    if (accept) begin
      front_cmd <= cls_cmd;
    end
  end

endmodule

// ===== rtl/tcce_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// tcce_cmd_queue: command queue
// Short first-in first-out queue between the input stage and the screen
// engine, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module tcce_cmd_queue import tcce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == CMDQ_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == CMDQ_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/tcce_back.sv =====
// ----------------------------------------------------------------------------
// tcce_back: screen engine
// Holds the cursor and the cell store, carries out commands, scrolls by
// moving the top row pointer and blanking one row, and holds the result.
// ----------------------------------------------------------------------------
module tcce_back import tcce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  logic [7:0]        attr,
  input  logic              pop,
  output logic              empty,
  output logic [15:0]       cell_value,
  output logic [LOC_W-1:0]  cursor_location,
  output logic              clearing
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_READ,
    ST_BLANK
  } state_t;

  state_t             state, state_next;
  logic [ROW_W-1:0]   cur_row, cur_row_next;
  logic [COL_W-1:0]   cur_col, cur_col_next;
  logic [ROW_W-1:0]   top_row, top_row_next;
  logic [ROW_W-1:0]   blank_row, blank_row_next;
  logic [COL_W-1:0]   blank_col, blank_col_next;
  logic [ADDR_W-1:0]  clr_cnt, clr_cnt_next;
  logic               out_valid, out_valid_next;
  logic [15:0]        out_cell, out_cell_next;
  logic [LOC_W-1:0]   out_loc, out_loc_next;

  logic [15:0]        mem [CELL_COUNT];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [15:0]        mem_wdata;
  logic [ADDR_W-1:0]  rd_addr;
  logic [15:0]        rd_data;

  logic               take;
  logic [COL_W:0]     col_n;
  logic [ROW_W:0]     row_n;
  logic [ROW_W-1:0]   row_fin;
  logic [COL_W-1:0]   col_fin;

  assign take     = (state == ST_RUN) && cmd_valid && (!out_valid || pop);
  assign cmd_pop  = take;
  assign rd_addr  = cell_addr(phys_row(cmd.rrow, top_row), cmd.rcol);
  assign clearing = (state == ST_CLEAR);

  // Cursor movement of a put
  always_comb begin
    col_n = {1'b0, cur_col};
    row_n = {1'b0, cur_row};
    unique case (cmd.kind)
      K_CR: begin
        col_n = '0;
      end
      K_LF: begin
        col_n = '0;
        row_n = row_n + 1'b1;
      end
      K_BS: begin
        if (cur_col != '0) begin
          col_n = col_n - 1'b1;
        end
      end
      K_TAB: begin
        col_n = (col_n + (COL_W+1)'(TAB_STOP)) & ~(COL_W+1)'(TAB_STOP - 1);
      end
      K_PRINT: begin
        col_n = col_n + 1'b1;
      end
      default: begin
      end
    endcase
    // Wrap to the next row at the right edge
    if (int'(col_n) >= COLUMNS) begin
      col_n = '0;
      row_n = row_n + 1'b1;
    end
    row_fin = (int'(row_n) >= ROWS) ? ROW_W'(ROWS - 1) : row_n[ROW_W-1:0];
    col_fin = col_n[COL_W-1:0];
  end

  // Sequence commands, clearing and row blanking
  always_comb begin
    state_next     = state;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    top_row_next   = top_row;
    blank_row_next = blank_row;
    blank_col_next = blank_col;
    clr_cnt_next   = clr_cnt;
    out_valid_next = out_valid && !pop;
    out_cell_next  = out_cell;
    out_loc_next   = out_loc;
    mem_we         = 1'b0;
    mem_waddr      = clr_cnt;
    mem_wdata      = RESET_CELL;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (int'(clr_cnt) == CELL_COUNT - 1) begin
          state_next = ST_RUN;
        end else begin
          clr_cnt_next = clr_cnt + 1'b1;
        end
      end
      ST_RUN: begin
        if (take) begin
          if (cmd.kind == K_READ) begin
            state_next = ST_READ;
          end else if (cmd.kind == K_READ_OFF) begin
            out_valid_next = 1'b1;
            out_cell_next  = '0;
            out_loc_next   = loc_of(cur_row, cur_col);
          end else begin
            if (cmd.kind == K_PRINT) begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(phys_row(cur_row, top_row), cur_col);
              mem_wdata = {attr, cmd.code};
            end
            cur_row_next   = row_fin;
            cur_col_next   = col_fin;
            out_valid_next = 1'b1;
            out_cell_next  = '0;
            out_loc_next   = loc_of(row_fin, col_fin);
            // Scroll: the old top row becomes the blank bottom row
            if (int'(row_n) >= ROWS) begin
              blank_row_next = top_row;
              blank_col_next = '0;
              top_row_next   = (int'(top_row) == ROWS - 1) ? '0 : top_row + 1'b1;
              state_next     = ST_BLANK;
            end
          end
        end
      end
      ST_READ: begin
        out_valid_next = 1'b1;
        out_cell_next  = rd_data;
        out_loc_next   = loc_of(cur_row, cur_col);
        state_next     = ST_RUN;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(blank_row, blank_col);
        mem_wdata = {attr, CH_SPACE};
        if (int'(blank_col) == COLUMNS - 1) begin
          state_next = ST_RUN;
        end else begin
          blank_col_next = blank_col + 1'b1;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cur_row   <= '0;
      cur_col   <= '0;
      top_row   <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      top_row   <= top_row_next;
      clr_cnt   <= clr_cnt_next;
      out_valid <= out_valid_next;
    end
    blank_row <= blank_row_next;
    blank_col <= blank_col_next;
    out_cell  <= out_cell_next;
    out_loc   <= out_loc_next;
  end

  // Cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  assign empty           = !out_valid;
  assign cell_value      = out_cell;
  assign cursor_location = out_loc;

endmodule

// ===== rtl/text_console_character_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_character_engine: text terminal over a character-cell store
// Input queue side: push/full with operation, char_code, read_row and
// read_column. Result queue side: empty/pop with cell_value and
// cursor_location; the oldest result is shown while empty is low.
// APB port: text_attribute at byte address 0, written in the access cycle.
// Each item gives one result. A put or an off-screen read is carried out by
// the screen engine in its run state, a read of a cell also passes the read
// state (registered store read); each item passes through the input stage
// and the command queue before the screen engine registers its result, and
// items are taken back to back while the command queue has room.
// A put that scrolls holds the screen engine while the new bottom row is
// blanked through the single store write port.
// After reset the store is cleared to blanks with attribute 0x0F, one cell a
// cycle, over all ROWS*COLUMNS cells (2000); full stays high meanwhile, while
// configuration writes are still taken.
// When the receiver stalls, the result register holds; the command queue and
// input stage then fill and full rises.
// ----------------------------------------------------------------------------
module text_console_character_engine import tcce_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               operation,
  input  logic [7:0]         char_code,
  input  logic [4:0]         read_row,
  input  logic [6:0]         read_column,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        cell_value,
  output logic [LOC_W-1:0]   cursor_location,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] text_attribute;
  logic       clearing;
  logic       q_full;
  logic       q_push;
  cmd_t       q_din;
  logic       q_empty;
  cmd_t       q_dout;
  logic       cmd_pop;
  logic       reg_sel;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_TEXT_ATTR);
  assign prdata  = reg_sel ? {24'b0, text_attribute} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= RESET_ATTR;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      text_attribute <= pwdata[7:0];
    end
  end

  tcce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .operation   (operation),
    .char_code   (char_code),
    .read_row    (read_row),
    .read_column (read_column),
    .clearing    (clearing),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_din       (q_din)
  );

  tcce_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  tcce_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd             (q_dout),
    .cmd_valid       (!q_empty),
    .cmd_pop         (cmd_pop),
    .attr            (text_attribute),
    .pop             (pop),
    .empty           (empty),
    .cell_value      (cell_value),
    .cursor_location (cursor_location),
    .clearing        (clearing)
  );

`ifndef SYNTHESIS
  // After reset no result waits and no item is taken during the clear
  a_reset_quiet: assert property (@(posedge clk) rst |=> empty && full)
    else $error("result or input open right after reset");

  // The engine only takes commands that are queued
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !q_empty)
    else $error("command taken from an empty queue");

  // A reported cursor lies on the screen
  a_loc_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (CELL_COUNT > 2048) || (int'(cursor_location) < CELL_COUNT))
    else $error("cursor location beyond the screen");
`endif

endmodule

// ===== tb/text_console_character_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_character_engine_tb: self-checking bench for the text console
// A queue-fed driver pushes put and read commands; a shadow screen with its
// own cursor and attribute predicts every reply, and a monitor pops replies
// and compares them field by field. Phases vary sender gaps, receiver stalls
// and the text attribute, and one phase holds the receiver off to fill the
// block.
// ----------------------------------------------------------------------------
module text_console_character_engine_tb;
  import tcce_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = COLUMNS + 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;
  localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * int'(REG_TEXT_ATTR));

  typedef struct packed {
    logic       op;
    logic [7:0] code;
    logic [4:0] row;
    logic [6:0] col;
  } console_cmd_t;

  typedef struct packed {
    logic [15:0]      cell_data;
    logic [LOC_W-1:0] loc;
  } screen_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               operation = OP_PUT;
  logic [7:0]         char_code = '0;
  logic [4:0]         read_row = '0;
  logic [6:0]         read_column = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [15:0]        cell_value;
  logic [LOC_W-1:0]   cursor_location;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow screen state
  logic [15:0]     shadow_screen [CELL_COUNT];
  int              shadow_row = 0;
  int              shadow_col = 0;
  logic [7:0]      shadow_attr = RESET_ATTR;

  console_cmd_t    pending_cmds[$];
  screen_reply_t   expected_replies[$];
  console_cmd_t    next_cmd;
  screen_reply_t   front_reply;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  logic            pressure_on = 1'b0;
  int              hold_count = 0;
  logic            receiver_hold;
  int              error_count = 0;
  int              reply_count = 0;
  int              cycle_count = 0;

  text_console_character_engine i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .operation(operation), .char_code(char_code),
    .read_row(read_row), .read_column(read_column),
    .empty(empty), .pop(pop),
    .cell_value(cell_value), .cursor_location(cursor_location),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endfunction

  // Apply one command to the shadow screen and queue the reply it gives
  function automatic void screen_model_step(input console_cmd_t cmd);
    screen_reply_t rep;
    int k;
    rep.cell_data = '0;
    if (cmd.op == OP_PUT) begin
      case (cmd.code)
        CH_CR: shadow_col = 0;
        CH_LF: begin
          shadow_col = 0;
          shadow_row++;
        end
        CH_BS: if (shadow_col != 0) shadow_col--;
        CH_TAB: shadow_col = (shadow_col + TAB_STOP) & ~(TAB_STOP - 1);
        default: begin
          if (cmd.code >= CH_SPACE && cmd.code <= PRINT_LAST) begin
            shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, cmd.code};
            shadow_col++;
          end
        end
      endcase
      // wrap the column, then scroll off the bottom row
      if (shadow_col >= COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
      end
      if (shadow_row >= ROWS) begin
        for (k = 0; k < CELL_COUNT - COLUMNS; k++) shadow_screen[k] = shadow_screen[k + COLUMNS];
        for (k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++) shadow_screen[k] = {shadow_attr, CH_SPACE};
        shadow_row = ROWS - 1;
      end
    end else if (int'(cmd.row) < ROWS && int'(cmd.col) < COLUMNS) begin
      rep.cell_data = shadow_screen[int'(cmd.row) * COLUMNS + int'(cmd.col)];
    end
    rep.loc = LOC_W'(shadow_row * COLUMNS + shadow_col);
    expected_replies.push_back(rep);
  endfunction

  function automatic console_cmd_t make_put(input logic [7:0] code);
    console_cmd_t cmd;
    cmd.op   = OP_PUT;
    cmd.code = code;
    cmd.row  = 5'($urandom);
    cmd.col  = 7'($urandom);
    return cmd;
  endfunction

  function automatic console_cmd_t make_read(input logic [4:0] row, input logic [6:0] col);
    console_cmd_t cmd;
    cmd.op   = OP_READ;
    cmd.code = 8'($urandom);
    cmd.row  = row;
    cmd.col  = col;
    return cmd;
  endfunction

  function automatic console_cmd_t random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      if ($urandom_range(0, 9) == 0) return make_read(5'($urandom), 7'($urandom));
      return make_read(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
    end
    if (r < 28) return make_put(CH_LF);
    if (r < 31) return make_put(CH_CR);
    if (r < 36) return make_put(CH_BS);
    if (r < 43) return make_put(CH_TAB);
    if (r < 50) begin
      if ($urandom_range(0, 1) == 0) return make_put(8'($urandom_range(0, 31)));
      return make_put(8'($urandom_range(128, 255)));
    end
    return make_put(8'($urandom_range(32, 127)));
  endfunction

  // Mostly single commands, with line-feed runs to reach the bottom row and
  // long printable runs to wrap lines
  task automatic queue_random_cmds(input int n);
    int added;
    int r;
    int len;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        len = $urandom_range(5, 26);
        repeat (len) pending_cmds.push_back(make_put(CH_LF));
        added += len;
      end else if (r < 8) begin
        len = $urandom_range(20, 90);
        repeat (len) pending_cmds.push_back(make_put(8'($urandom_range(32, 127))));
        added += len;
      end else begin
        pending_cmds.push_back(random_cmd());
        added++;
      end
    end
  endtask

  task automatic queue_directed_cmds();
    pending_cmds.push_back(make_put(8'h41));
    pending_cmds.push_back(make_put(CH_SPACE));
    pending_cmds.push_back(make_put(PRINT_LAST));
    pending_cmds.push_back(make_put(8'h1F));
    pending_cmds.push_back(make_put(8'h00));
    pending_cmds.push_back(make_put(8'h80));
    pending_cmds.push_back(make_put(8'hFF));
    pending_cmds.push_back(make_put(CH_BS));
    pending_cmds.push_back(make_put(CH_TAB));
    pending_cmds.push_back(make_put(CH_TAB));
    pending_cmds.push_back(make_put(CH_CR));
    pending_cmds.push_back(make_put(CH_BS));
    pending_cmds.push_back(make_put(CH_LF));
    pending_cmds.push_back(make_put(CH_TAB));
    pending_cmds.push_back('{op: OP_PUT, code: 8'h7E, row: '1, col: '1});
    pending_cmds.push_back(make_read(5'd0, 7'd0));
    pending_cmds.push_back(make_read(5'd0, 7'd2));
    pending_cmds.push_back(make_read(5'(ROWS - 1), 7'(COLUMNS - 1)));
    pending_cmds.push_back('{op: OP_READ, code: 8'hFF, row: 5'd1, col: 7'd0});
    pending_cmds.push_back('{op: OP_READ, code: 8'h00, row: '1, col: '1});
    pending_cmds.push_back(make_read(5'(ROWS), 7'd0));
    pending_cmds.push_back(make_read(5'd0, 7'(COLUMNS)));
  endtask

  // APB write of the attribute, then read it back
  task automatic write_text_attr(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    shadow_attr = value;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != 32'(value)) begin
      note_error($sformatf("text_attribute read exp %h got %h", 32'(value), prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every command is taken and every reply has come, then settle
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || push || expected_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Driver: predict on each input transfer, then offer the next command
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        screen_model_step('{op: operation, code: char_code, row: read_row, col: read_column});
      end
      if (!push || !full) begin
        if (pending_cmds.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          push        <= 1'b1;
          operation   <= next_cmd.op;
          char_code   <= next_cmd.code;
          read_row    <= next_cmd.row;
          read_column <= next_cmd.col;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off while pressure is on
  always @(posedge clk) begin
    if (!pressure_on) begin
      hold_count <= 0;
    end else if (hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
    end
  end

  assign receiver_hold = pressure_on && (hold_count < HOLD_CYCLES);

  // Monitor: check each output transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_replies.size() == 0) begin
          note_error($sformatf("unexpected reply cell %h loc %0d", cell_value, cursor_location));
        end else begin
          front_reply = expected_replies.pop_front();
          if (cell_value !== front_reply.cell_data) begin
            note_error($sformatf("reply %0d cell_value exp %h got %h",
                                 reply_count, front_reply.cell_data, cell_value));
          end
          if (cursor_location !== front_reply.loc) begin
            note_error($sformatf("reply %0d cursor_location exp %0d got %0d",
                                 reply_count, front_reply.loc, cursor_location));
          end
        end
        reply_count++;
      end
      pop <= !(receiver_hold || $urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sequence the phases
  initial begin
    for (int k = 0; k < CELL_COUNT; k++) shadow_screen[k] = RESET_CELL;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no idling, reset attribute
    queue_directed_cmds();
    queue_random_cmds(100);
    wait_idle();

    write_text_attr(8'h00);
    @(negedge clk);
    send_idle_pct = 61;
    queue_random_cmds(100);
    wait_idle();

    write_text_attr(8'hFF);
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    queue_random_cmds(100);
    wait_idle();

    write_text_attr(8'($urandom));
    @(negedge clk);
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    queue_random_cmds(100);
    wait_idle();

    // hold the receiver off so the block fills and stalls its input
    write_text_attr(8'($urandom));
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_on    = 1'b1;
    queue_random_cmds(30);
    wait_idle();
    pressure_on = 1'b0;

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== text_console_character_engine.f =====
rtl/tcce_pkg.sv
rtl/tcce_front.sv
rtl/tcce_cmd_queue.sv
rtl/tcce_back.sv
rtl/text_console_character_engine.sv
tb/text_console_character_engine_tb.sv
